// ===== rtl/msr_pkg.sv =====
// Shared types and constants of the multidrop serial slave receiver.
// Holds the phase encoding, reply codes and the result record.
// No dependencies.
package msr_pkg;

    localparam logic [7:0] ADDR_RESET   = 8'h01;
    localparam logic [7:0] PORT_RESET   = 8'hff;
    localparam logic [7:0] CODE_SUCCESS = 8'h0f;
    localparam logic [7:0] CODE_ERROR   = 8'hf0;

    typedef enum logic [3:0] {
        PH_ADDR  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_CHECK = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        REPLY_ECHO    = 2'd0,
        REPLY_SUCCESS = 2'd1,
        REPLY_ERROR   = 2'd2
    } reply_kind_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  tx_byte;
        reply_kind_t reply_kind;
        logic [7:0]  port_value;
        logic        port_changed;
    } result_t;

endpackage

// ===== rtl/msr_frame_ctrl.sv =====
// Frame sequencer of the multidrop serial slave receiver.
// Tracks address, length, data and check phases; forms the reply of one beat.
// Depends on msr_pkg.
module msr_frame_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  logic             ninth_bit,
    input  logic [7:0]       own_address,
    output msr_pkg::result_t result
);
    import msr_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [1:0] position_reg, position_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] port_reg, port_next;
    logic [7:0] check_xor;

    assign check_xor = xor_reg ^ rx_byte;

    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        position_next  = position_reg;
        xor_next       = xor_reg;
        held_next      = held_reg;
        port_next      = port_reg;
        result         = '{valid: 1'b0, tx_byte: own_address, reply_kind: REPLY_ECHO,
                           port_value: port_reg, port_changed: 1'b0};
        if (phase_reg != PH_ADDR && ninth_bit) begin
            // abort reception, discard the address frame
            phase_next     = PH_ADDR;
            remaining_next = 8'd0;
            position_next  = 2'd0;
            xor_next       = 8'd0;
        end else begin
            unique case (phase_reg)
                PH_ADDR: begin
                    if (ninth_bit && rx_byte == own_address) begin
                        phase_next   = PH_LEN;
                        result.valid = 1'b1;
                    end
                end
                PH_LEN: begin
                    remaining_next = rx_byte;
                    position_next  = 2'd0;
                    xor_next       = rx_byte;
                    phase_next     = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA: begin
                    if (position_reg == 2'd1) begin
                        held_next = rx_byte;
                    end
                    xor_next       = check_xor;
                    position_next  = (position_reg == 2'd2) ? 2'd2 : position_reg + 2'd1;
                    remaining_next = remaining_reg - 8'd1;
                    if (remaining_reg == 8'd1) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    remaining_next = 8'd0;
                    position_next  = 2'd0;
                    xor_next       = 8'd0;
                    result.valid   = 1'b1;
                    if (check_xor != 8'd0) begin
                        phase_next        = PH_LEN;
                        result.tx_byte    = CODE_ERROR;
                        result.reply_kind = REPLY_ERROR;
                    end else begin
                        phase_next          = PH_ADDR;
                        port_next           = held_reg;
                        result.tx_byte      = CODE_SUCCESS;
                        result.reply_kind   = REPLY_SUCCESS;
                        result.port_value   = held_reg;
                        result.port_changed = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_ADDR;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_ADDR;
            remaining_reg <= 8'd0;
            position_reg  <= 2'd0;
            xor_reg       <= 8'd0;
            held_reg      <= 8'd0;
            port_reg      <= PORT_RESET;
        end else if (step) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            position_reg  <= position_next;
            xor_reg       <= xor_next;
            held_reg      <= held_next;
            port_reg      <= port_next;
        end
    end

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> phase_reg == PH_ADDR && port_reg == PORT_RESET && held_reg == 8'd0)
        else $error("state not cleared by reset");

    a_success_loads_port: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_CHECK && !ninth_bit && check_xor == 8'd0
        |=> port_reg == $past(held_reg) && phase_reg == PH_ADDR)
        else $error("good check did not load port");

    a_bad_check_relen: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_CHECK && !ninth_bit && check_xor != 8'd0
        |=> phase_reg == PH_LEN && xor_reg == 8'd0 && $stable(port_reg))
        else $error("bad check did not return to length phase");

    a_data_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> remaining_reg != 8'd0)
        else $error("data phase with zero remaining count");

    a_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg != PH_ADDR && ninth_bit |-> !result.valid)
        else $error("abort produced a reply");

endmodule

// ===== rtl/multidrop_serial_slave_receiver.sv =====
// Top level of the multidrop serial slave receiver: input register, result register.
// Depends on msr_pkg and msr_frame_ctrl.
//
// channel  direction  tdata                                        tuser
// s_       in         [7:0] rx_byte                                [0] ninth_bit
// m_       out        [7:0] tx_byte, [15:8] port_value, [16] chg   [1:0] reply_kind
// cfg_     in         cfg_wr_data = own_address, written when cfg_wr_en
//
// One beat per cycle while m_tready is high; replies pass the input then the result register.
// The frame sequencer steps once per beat moved from the input to the result register.
// While a reply waits on m_tready, it holds and one more beat parks in the input register.
// Synchronous active-low reset clears the sequencer, own_address to 0x01, port to 0xff.
module multidrop_serial_slave_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] ninth_bit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] tx_byte, [15:8] port_value, [16] port_changed
    output logic [1:0]  m_tuser    // [1:0] reply_kind
);
    import msr_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_ninth_reg;
    logic       out_valid_reg;
    logic [7:0] out_tx_reg;
    logic [1:0] out_kind_reg;
    logic [7:0] out_port_reg;
    logic       out_chg_reg;
    logic [7:0] own_addr_reg;
    logic       advance;
    result_t    result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg <= ADDR_RESET;
        end else if (cfg_wr_en) begin
            own_addr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_ninth_reg <= s_tuser;
        end
    end

    msr_frame_ctrl u_frame_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .ninth_bit   (in_ninth_reg),
        .own_address (own_addr_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            out_tx_reg   <= result.tx_byte;
            out_kind_reg <= result.reply_kind;
            out_port_reg <= result.port_value;
            out_chg_reg  <= result.port_changed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_chg_reg, out_port_reg, out_tx_reg};
    assign m_tuser  = out_kind_reg;

endmodule
